### hdl/huffman_table_bit_packer_top_defines.svh
// ----------------------------------------------------------------------------
// Huffman table bit packer assertion macros
// Shared property macros for the checker of the bit packer.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_BIT_PACKER_TOP_DEFINES_SVH
`define HUFFMAN_TABLE_BIT_PACKER_TOP_DEFINES_SVH

// Overlapping implication, disabled while reset is held.
`define HBP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bit packer property failed");

// Next-cycle implication, disabled while reset is held.
`define HBP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bit packer property failed");

`endif

### hdl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman table bit packer package
// Widths, defaults and the control and status types of the packing unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

    localparam int SYMBOL_BYTES_DEF  = 2;
    localparam int MAX_CODE_BITS_DEF = 31;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int CODE_W      = 31;
    localparam int TABLE_AW    = 16;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;

    // Commands from the sequencer to the packing unit.
    typedef struct packed {
        logic load;   // take a table entry as the current code
        logic step;   // move one packing step forward
        logic clear;  // empty the accumulator after a flush
    } hbp_pack_ctrl_t;

    // What the packing unit shows for the current step.
    typedef struct packed {
        logic              emit;       // this step completes a byte
        logic              sym_done;   // no code bits remain after this step
        logic              last_byte;  // no later step of this code completes a byte
        logic [BYTE_W-1:0] byte_val;   // the completed byte
        logic [BYTE_W-1:0] acc_val;    // the partial byte, for the flush
    } hbp_pack_stat_t;

endpackage

`default_nettype wire

### hdl/huffman_table_bit_packer_top.sv
// ----------------------------------------------------------------------------
// Huffman table bit packer
// Table-driven Huffman encoder that packs looked-up codes into bytes.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries load beats (s_func low), which write one code table
// entry, and data beats (s_func high), which carry one stream byte. Data bytes
// pair big-endian into symbols; each symbol's code is read from the table and
// packed most significant bit first. The m_ channel returns every completed
// byte, with m_run_last on the last byte caused by a beat and m_final_flush on
// the partial byte emitted at stream end.
// A load beat writes one table entry. A data beat that only holds its byte
// keeps it as the pending byte; one that completes a symbol goes through the
// table read and the entry hand-over, then packing steps of up to one byte of
// bits each until the code is used, plus the flush on stream end. The single
// read port of the code table and the one-byte-per-step packer set this order.
// After reset the table is swept to length zero, one entry a cycle, over all
// 65536 entries while s_ready stays low. A stalled receiver holds the output
// register and the packer waits at the next byte it must emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_table_bit_packer_top #(
    parameter int SYMBOL_BYTES  = hbp_pkg::SYMBOL_BYTES_DEF,
    parameter int MAX_CODE_BITS = hbp_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [hbp_pkg::TABLE_AW-1:0]   s_table_index,
    input  logic [hbp_pkg::LEN_W-1:0]      s_code_length,
    input  logic [hbp_pkg::CODE_W-1:0]     s_code_value,
    input  logic [hbp_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                           s_stream_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hbp_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                           m_run_last,
    output logic                           m_final_flush
);

    import hbp_pkg::*;

    localparam int ENTRY_W = LEN_W + MAX_CODE_BITS;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0]          state_reg,   state_next;
    logic [TABLE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [BYTE_W-1:0]   pend_reg,    pend_next;
    logic                pend_vld_reg, pend_vld_next;
    logic                last_reg,    last_next;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_byte_reg,  m_byte_next;
    logic                m_rl_reg,    m_rl_next;
    logic                m_ff_reg,    m_ff_next;

    logic                accept;
    logic                load_beat;
    logic                out_free;
    logic                has_symbol;
    logic [TABLE_AW-1:0] symbol;
    logic [LEN_W-1:0]    len_sat;

    logic                ram_we;
    logic [TABLE_AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    hbp_pack_ctrl_t      pk_ctrl;
    hbp_pack_stat_t      pk_stat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign load_beat = accept && !s_func;
    assign out_free  = !m_valid_reg || m_ready;
    assign len_sat   = (s_code_length > LEN_W'(MAX_CODE_BITS)) ?
                       LEN_W'(MAX_CODE_BITS) : s_code_length;

    // Symbol formed from the beat being accepted; the table read runs every
    // cycle, so the entry is ready in the cycle after acceptance.
    always_comb begin
        if (SYMBOL_BYTES >= 2) begin
            if (pend_vld_reg) begin
                symbol     = {pend_reg, s_data_byte};
                has_symbol = 1'b1;
            end else begin
                symbol     = {s_data_byte, {BYTE_W{1'b0}}};
                has_symbol = s_stream_end && (s_data_byte != '0);
            end
        end else begin
            symbol     = {{(TABLE_AW-BYTE_W){1'b0}}, s_data_byte};
            has_symbol = 1'b1;
        end
    end

    // A load writes at its acceptance edge and the earliest read follows it,
    // so no forwarding is needed on the table.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = load_beat;
            ram_waddr = s_table_index;
            ram_wdata = {len_sat, s_code_value[MAX_CODE_BITS-1:0]};
        end
    end

    hbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (symbol),
        .rdata (ram_rdata)
    );

    hbp_bit_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (pk_ctrl),
        .entry_len  (ram_rdata[ENTRY_W-1 -: LEN_W]),
        .entry_code (ram_rdata[MAX_CODE_BITS-1:0]),
        .stat       (pk_stat)
    );

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_next   = m_byte_reg;
        m_rl_next     = m_rl_reg;
        m_ff_next     = m_ff_reg;
        pk_ctrl       = '0;

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + TABLE_AW'(1);
                if (clr_cnt_reg == {TABLE_AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && s_func) begin
                    last_next = s_stream_end;
                    if (SYMBOL_BYTES >= 2) begin
                        if (pend_vld_reg || s_stream_end) begin
                            pend_next     = '0;
                            pend_vld_next = 1'b0;
                        end else begin
                            pend_next     = s_data_byte;
                            pend_vld_next = 1'b1;
                        end
                    end
                    if (has_symbol) begin
                        state_next = ST_LOOKUP;
                    end else if (s_stream_end) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_LOOKUP: begin
                pk_ctrl.load = 1'b1;
                state_next   = ST_SHIFT;
            end
            ST_SHIFT: begin
                // Stall only when this step completes a byte and the output is held.
                if (!pk_stat.emit || out_free) begin
                    pk_ctrl.step = 1'b1;
                    if (pk_stat.emit) begin
                        m_valid_next = 1'b1;
                        m_byte_next  = pk_stat.byte_val;
                        m_rl_next    = pk_stat.last_byte && !last_reg;
                        m_ff_next    = 1'b0;
                    end
                    if (pk_stat.sym_done) begin
                        state_next = last_reg ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    pk_ctrl.clear = 1'b1;
                    m_valid_next  = 1'b1;
                    m_byte_next   = pk_stat.acc_val;
                    m_rl_next     = 1'b1;
                    m_ff_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pend_reg     <= '0;
            pend_vld_reg <= 1'b0;
            last_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pend_reg     <= pend_next;
            pend_vld_reg <= pend_vld_next;
            last_reg     <= last_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_rl_reg   <= m_rl_next;
        m_ff_reg   <= m_ff_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_run_last    = m_rl_reg;
    assign m_final_flush = m_ff_reg;

endmodule

`default_nettype wire

### hdl/hbp_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbp_ram #(
    parameter int WIDTH = hbp_pkg::LEN_W + hbp_pkg::MAX_CODE_BITS_DEF,
    parameter int DEPTH = hbp_pkg::TABLE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/hbp_bit_packer.sv
// ----------------------------------------------------------------------------
// Huffman bit packing unit
// Left-aligns a code and packs it into bytes, up to one byte of bits per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbp_bit_packer #(
    parameter int MAX_CODE_BITS = hbp_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hbp_pkg::hbp_pack_ctrl_t     ctrl,
    input  logic [hbp_pkg::LEN_W-1:0]   entry_len,
    input  logic [MAX_CODE_BITS-1:0]    entry_code,
    output hbp_pkg::hbp_pack_stat_t     stat
);

    import hbp_pkg::*;

    logic [BYTE_W-1:0]        acc_reg,    acc_next;
    logic [2:0]               filled_reg, filled_next;
    logic [LEN_W-1:0]         rem_reg,    rem_next;
    logic [MAX_CODE_BITS-1:0] code_reg,   code_next;

    logic [3:0]               space;
    logic [3:0]               take;
    logic [3:0]               fill_sum;
    logic [BYTE_W-1:0]        top_bits;
    logic [BYTE_W-1:0]        acc_or;
    logic                     full;
    logic [LEN_W-1:0]         rem_after;
    logic [LEN_W-1:0]         align_sh;

    always_comb begin
        space     = 4'd8 - {1'b0, filled_reg};
        // Take what is left of the code or what fits in the byte, whichever is less.
        take      = (rem_reg < {1'b0, space}) ? rem_reg[3:0] : space;
        top_bits  = code_reg[MAX_CODE_BITS-1 -: BYTE_W];
        // Bits below the remaining length are zero, so over-reading is harmless.
        acc_or    = acc_reg | (top_bits >> filled_reg);
        fill_sum  = {1'b0, filled_reg} + take;
        full      = (fill_sum == 4'd8);
        rem_after = rem_reg - {1'b0, take};
        align_sh  = LEN_W'(MAX_CODE_BITS) - entry_len;

        stat.emit      = full;
        stat.sym_done  = (rem_after == '0);
        // After a completed byte the accumulator is empty, so fewer than eight
        // remaining bits can never fill another one.
        stat.last_byte = (rem_after < LEN_W'(BYTE_W));
        stat.byte_val  = acc_or;
        stat.acc_val   = acc_reg;

        acc_next    = acc_reg;
        filled_next = filled_reg;
        rem_next    = rem_reg;
        code_next   = code_reg;

        if (ctrl.load) begin
            rem_next  = entry_len;
            code_next = entry_code << align_sh;
        end else if (ctrl.step) begin
            rem_next  = rem_after;
            code_next = code_reg << take;
            if (full) begin
                acc_next    = '0;
                filled_next = '0;
            end else begin
                acc_next    = acc_or;
                filled_next = fill_sum[2:0];
            end
        end else if (ctrl.clear) begin
            acc_next    = '0;
            filled_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            filled_reg <= '0;
            rem_reg    <= '0;
        end else begin
            acc_reg    <= acc_next;
            filled_reg <= filled_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

endmodule

`default_nettype wire

### hdl/hbp_checker.sv
// ----------------------------------------------------------------------------
// Huffman table bit packer checker
// Port-level properties of the bit packer, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_table_bit_packer_top_defines.svh"

module hbp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_run_last,
    input wire logic       m_final_flush
);

    // A held result beat keeps its payload.
    `HBP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_run_last) && $stable(m_final_flush))

    // The flushed byte is always the last beat of its item.
    `HBP_ASSERT_IMP(a_flush_is_last, aclk, aresetn, m_valid && m_final_flush, m_run_last)

    // While an item's bytes are still coming, no new beat is taken.
    `HBP_ASSERT_IMP(a_busy_mid_item, aclk, aresetn, m_valid && !m_run_last, !s_ready)

endmodule

bind huffman_table_bit_packer_top hbp_checker u_hbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_run_last    (m_run_last),
    .m_final_flush (m_final_flush)
);

`default_nettype wire
